### rtl/parallel_nibble_frame_receiver_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the parallel nibble frame receiver
// Checks on clk with a synchronous active-high reset rst; compiled out
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_NIBBLE_FRAME_RECEIVER_TOP_ASSERT_SVH
`define PARALLEL_NIBBLE_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTH

// Condition that must hold at every clock edge outside reset.
`define PNFR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define PNFR_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`else

`define PNFR_ASSERT_ALWAYS(label, cond, msg)
`define PNFR_ASSERT_NEXT(label, trig, cond, msg)

`endif

`endif

### rtl/pnfr_pkg.sv
// ----------------------------------------------------------------------------
// pnfr_pkg
// Types and constants for the parallel nibble frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package pnfr_pkg;

  // Register widths and reset values.
  localparam int unsigned TimeoutWidth = 16;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [15:0] TimeoutReset  = 16'd10000;
  localparam logic [7:0]  MagicReset    = 8'hd7;
  localparam logic [3:0]  HuntAckReset  = 4'hb;
  localparam logic [3:0]  FrameAckReset = 4'h2;
  localparam logic [4:0]  DriveReset    = 5'h10;

  // Configuration register indexes.
  localparam logic [1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_MAGIC     = 2'd1;
  localparam logic [1:0] REG_HUNT_ACK  = 2'd2;
  localparam logic [1:0] REG_FRAME_ACK = 2'd3;

  // Reception phase.
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SIZE  = 3'd1,
    PH_CHECK = 3'd2,
    PH_DATA  = 3'd3,
    PH_HALT  = 3'd4
  } phase_t;

  // Event code reported with each result.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_BYTE     = 3'd1,
    EV_OK       = 3'd2,
    EV_MISMATCH = 3'd3,
    EV_TIMEOUT  = 3'd4,
    EV_END      = 3'd5,
    EV_RETRY    = 3'd6
  } event_t;

endpackage

`default_nettype wire

### rtl/parallel_nibble_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// Parallel nibble frame receiver.
// Input channel (in_valid/in_ready, status_lines): one transaction is one
// sample of the five status lines, data nibble in bits 3..0, sender strobe
// in bit 4. Output channel (out_valid/out_ready): exactly one result per
// sample with the drive value, an optional payload byte, an event code and
// the block sum reported with block-ok and checksum-mismatch events.
// The result of a sample is loaded into the result register on the edge
// that accepts it. The receiver takes one sample per cycle while out_ready
// is high; the nibble, byte, word and checksum update sits between the
// state registers and the result register.
// The result register frees its slot while being read, so in_ready stays
// high while out_ready is high; when the receiver stalls (out_ready low
// with a result held) in_ready drops and nothing advances.
// Reset restores the register defaults, returns to hunting the start byte
// and drives 0x10 (clock high, ack zero). After an end frame or a timeout
// past the start the block halts: samples are still taken and answered,
// with the drive value held and all other fields zero, until reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "parallel_nibble_frame_receiver_top_assert.svh"

module parallel_nibble_frame_receiver_top
  import pnfr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [4:0]               status_lines,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [4:0]                    drive_value,
  output logic                          byte_valid,
  output logic [7:0]                    byte_value,
  output logic [2:0]                    event_res,
  output logic [15:0]                   sum_value
);

  // Configuration registers.
  logic [TimeoutWidth-1:0] timeout_limit;
  logic [7:0]              open_byte;
  logic [3:0]              hunt_ack;
  logic [3:0]              frame_ack;

  // Receiver state.
  phase_t      phase, phase_next;
  logic [1:0]  nibble_index, nibble_index_next;
  logic [15:0] assembled_word, assembled_word_next;
  logic [15:0] block_size, block_size_next;
  logic [15:0] expected_sum, expected_sum_next;
  logic [15:0] running_sum, running_sum_next;
  logic [15:0] bytes_done, bytes_done_next;
  logic [TimeoutWidth-1:0] wait_count, wait_count_next;
  logic [4:0]  previous_sample, previous_sample_next;
  logic        previous_valid, previous_valid_next;
  logic [4:0]  drive_register, drive_register_next;

  // Result of the current sample.
  event_t      ev_next;
  logic        bvalid_next;
  logic [7:0]  bval_next;
  logic [15:0] sumv_next;

  // Shared decode of the current sample.
  logic        take;
  logic        active;
  logic        clk_phase;
  logic        sample_ok;
  logic        nib_accept;
  logic        word_phase;
  logic [7:0]  asm_byte;
  logic [15:0] low_word;
  logic        byte_done;
  logic        word_done;
  logic [TimeoutWidth-1:0] wait_inc;
  logic        timed_out;
  logic [15:0] sum_inc;
  logic [15:0] done_inc;
  logic        block_last;

  // Result checks used by the assertions.
  logic        result_is_end;
  logic        byte_res_ok;
  logic        sum_res_ok;
  logic        halt_take;
  logic        halt_quiet;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign active     = (phase != PH_HALT);
  assign clk_phase  = nibble_index[0];
  assign sample_ok  = previous_valid && (previous_sample == status_lines) &&
                      (status_lines[4] != clk_phase);
  assign nib_accept = active && sample_ok;
  assign word_phase = (phase == PH_SIZE) || (phase == PH_CHECK);
  assign asm_byte   = {status_lines[3:0], assembled_word[3:0]};
  assign low_word   = {assembled_word[15:8], asm_byte};
  assign byte_done  = nib_accept && (nibble_index == 2'd1) && !word_phase;
  assign word_done  = nib_accept && (nibble_index == 2'd3);
  assign wait_inc   = wait_count + TimeoutWidth'(1);
  assign timed_out  = active && !sample_ok && (wait_inc >= timeout_limit);
  assign sum_inc    = running_sum + {8'd0, asm_byte};
  assign done_inc   = bytes_done + 16'd1;
  assign block_last = (done_inc == block_size);

  // Next state of the receiver for the current sample.
  always_comb begin
    phase_next           = phase;
    nibble_index_next    = nibble_index;
    assembled_word_next  = assembled_word;
    block_size_next      = block_size;
    expected_sum_next    = expected_sum;
    running_sum_next     = running_sum;
    bytes_done_next      = bytes_done;
    wait_count_next      = wait_count;
    previous_sample_next = previous_sample;
    previous_valid_next  = previous_valid;
    drive_register_next  = drive_register;

    if (active) begin
      previous_sample_next = status_lines;
      previous_valid_next  = 1'b1;
    end

    if (nib_accept) begin
      previous_valid_next = 1'b0;
      wait_count_next     = '0;
      drive_register_next = {clk_phase, (phase == PH_HUNT) ? hunt_ack : frame_ack};

      // Nibble assembly: bytes low nibble first, words high byte first.
      case (nibble_index)
        2'd0: begin
          assembled_word_next = {12'd0, status_lines[3:0]};
          nibble_index_next   = 2'd1;
        end
        2'd1: begin
          if (word_phase) begin
            assembled_word_next = {asm_byte, 8'd0};
            nibble_index_next   = 2'd2;
          end else begin
            assembled_word_next = {8'd0, asm_byte};
            nibble_index_next   = 2'd0;
          end
        end
        2'd2: begin
          assembled_word_next = {assembled_word[15:8], 4'd0, status_lines[3:0]};
          nibble_index_next   = 2'd3;
        end
        default: begin
          assembled_word_next = low_word;
          nibble_index_next   = 2'd0;
        end
      endcase

      // Frame sequencing.
      if (phase == PH_HUNT && byte_done) begin
        if (asm_byte == open_byte) begin
          phase_next = PH_SIZE;
        end
      end else if (phase == PH_SIZE && word_done) begin
        if (low_word == 16'd0) begin
          phase_next = PH_HALT;
        end else begin
          block_size_next = low_word;
          phase_next      = PH_CHECK;
        end
      end else if (phase == PH_CHECK && word_done) begin
        expected_sum_next = low_word;
        running_sum_next  = '0;
        bytes_done_next   = '0;
        phase_next        = PH_DATA;
      end else if (phase == PH_DATA && byte_done) begin
        running_sum_next = sum_inc;
        bytes_done_next  = done_inc;
        if (block_last) begin
          phase_next = PH_SIZE;
        end
      end
    end else if (active) begin
      // No nibble taken: count toward the timeout.
      wait_count_next = wait_inc;
      if (timed_out) begin
        wait_count_next     = '0;
        nibble_index_next   = 2'd0;
        previous_valid_next = 1'b0;
        if (phase != PH_HUNT) begin
          phase_next = PH_HALT;
        end
      end
    end
  end

  // Result fields for the current sample.
  always_comb begin
    ev_next     = EV_NONE;
    bvalid_next = 1'b0;
    bval_next   = '0;
    sumv_next   = '0;

    if (nib_accept) begin
      if (phase == PH_SIZE && word_done && low_word == 16'd0) begin
        ev_next = EV_END;
      end else if (phase == PH_DATA && byte_done) begin
        bvalid_next = 1'b1;
        bval_next   = asm_byte;
        if (block_last) begin
          ev_next   = (sum_inc == expected_sum) ? EV_OK : EV_MISMATCH;
          sumv_next = sum_inc;
        end else begin
          ev_next = EV_BYTE;
        end
      end
    end else if (timed_out) begin
      ev_next = (phase == PH_HUNT) ? EV_RETRY : EV_TIMEOUT;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TimeoutReset;
      open_byte     <= MagicReset;
      hunt_ack      <= HuntAckReset;
      frame_ack     <= FrameAckReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TIMEOUT:   timeout_limit <= cfg_data[TimeoutWidth-1:0];
        REG_MAGIC:     open_byte     <= cfg_data[7:0];
        REG_HUNT_ACK:  hunt_ack      <= cfg_data[3:0];
        REG_FRAME_ACK: frame_ack     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Receiver state, advanced once per accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      nibble_index    <= 2'd0;
      assembled_word  <= '0;
      block_size      <= '0;
      expected_sum    <= '0;
      running_sum     <= '0;
      bytes_done      <= '0;
      wait_count      <= '0;
      previous_sample <= '0;
      previous_valid  <= 1'b0;
      drive_register  <= DriveReset;
    end else if (take) begin
      phase           <= phase_next;
      nibble_index    <= nibble_index_next;
      assembled_word  <= assembled_word_next;
      block_size      <= block_size_next;
      expected_sum    <= expected_sum_next;
      running_sum     <= running_sum_next;
      bytes_done      <= bytes_done_next;
      wait_count      <= wait_count_next;
      previous_sample <= previous_sample_next;
      previous_valid  <= previous_valid_next;
      drive_register  <= drive_register_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      drive_value <= drive_register_next;
      byte_valid  <= bvalid_next;
      byte_value  <= bval_next;
      event_res   <= ev_next;
      sum_value   <= sumv_next;
    end
  end

  // Properties of the held result.
  assign result_is_end = (event_res == EV_OK) || (event_res == EV_MISMATCH);
  assign byte_res_ok   = !byte_valid || (event_res == EV_BYTE) || result_is_end;
  assign sum_res_ok    = (sum_value == 16'd0) || result_is_end;
  assign halt_take     = take && (phase == PH_HALT);
  assign halt_quiet    = out_valid && !byte_valid && (event_res == EV_NONE) &&
                         (phase == PH_HALT);

  // A payload byte only comes with a byte or block-end event.
  `PNFR_ASSERT_ALWAYS(a_byte_event, !out_valid || byte_res_ok, "payload byte without byte event")

  // The block sum is only reported at block end.
  `PNFR_ASSERT_ALWAYS(a_sum_at_end, !out_valid || sum_res_ok, "sum reported outside block end")

  // A halted receiver answers with an empty result and stays halted.
  `PNFR_ASSERT_NEXT(a_halt_quiet, halt_take, halt_quiet, "halted receiver produced activity")

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the parallel nibble frame receiver
// Feeds status-line samples through the valid/ready input channel and checks
// every result transaction against a cycle-free model of the receiver.
// Stimulus walks the start-byte hunt, then streams frames with random
// content, noise, a checksum-wrapping block and a terminal stop.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pnfr_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 250;

  // Register settings of the model.
  typedef struct packed {
    logic [15:0] timeout_limit;
    logic [7:0]  open_byte;
    logic [3:0]  hunt_ack;
    logic [3:0]  frame_ack;
  } rx_cfg_t;

  // Receiver state of the model.
  typedef struct {
    phase_t      phase;
    logic [1:0]  nib_idx;
    logic [15:0] word;
    logic [15:0] block_size;
    logic [15:0] expected_sum;
    logic [15:0] running_sum;
    logic [15:0] bytes_done;
    logic [15:0] wait_count;
    logic [4:0]  prev_status;
    logic        prev_valid;
    logic [4:0]  drive;
  } rx_state_t;

  // One result transaction.
  typedef struct packed {
    logic [4:0]  drive;
    logic        byte_valid;
    logic [7:0]  byte_value;
    event_t      ev;
    logic [15:0] sum;
  } rx_reply_t;

  // Model of the receiver plus the queue of replies it still owes.
  class nibble_rx_scoreboard;
    rx_cfg_t   cfg;
    rx_state_t st;
    rx_reply_t due_replies[$];
    int        failures;

    function new();
      cfg = '{timeout_limit: TimeoutReset, open_byte: MagicReset,
              hunt_ack: HuntAckReset, frame_ack: FrameAckReset};
      st = '{phase: PH_HUNT, nib_idx: 2'd0, word: 16'd0, block_size: 16'd0,
             expected_sum: 16'd0, running_sum: 16'd0, bytes_done: 16'd0,
             wait_count: 16'd0, prev_status: 5'd0, prev_valid: 1'b0,
             drive: DriveReset};
      failures = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        REG_TIMEOUT:   cfg.timeout_limit = value;
        REG_MAGIC:     cfg.open_byte = value[7:0];
        REG_HUNT_ACK:  cfg.hunt_ack = value[3:0];
        REG_FRAME_ACK: cfg.frame_ack = value[3:0];
        default: ;
      endcase
    endfunction

    // Advances the receiver by one status sample and returns its reply.
    function void receive_status(logic [4:0] status, output rx_reply_t reply);
      logic       clk_bit;
      logic       take;
      logic       word_phase;
      logic       byte_done;
      logic       word_done;
      logic [3:0] nib;
      logic [3:0] ack;
      logic [7:0] octet;
      reply = '0;
      reply.ev = EV_NONE;
      if (st.phase != PH_HALT) begin
        clk_bit = st.nib_idx[0];
        take = st.prev_valid && (st.prev_status == status) && (status[4] != clk_bit);
        st.prev_status = status;
        st.prev_valid = 1'b1;
        if (take) begin
          nib = status[3:0];
          ack = (st.phase == PH_HUNT) ? cfg.hunt_ack : cfg.frame_ack;
          word_phase = (st.phase == PH_SIZE) || (st.phase == PH_CHECK);
          byte_done = 1'b0;
          word_done = 1'b0;
          octet = 8'd0;
          st.prev_valid = 1'b0;
          st.wait_count = 16'd0;
          st.drive = {clk_bit, ack};
          // Nibbles build bytes low first; bytes build words high first.
          case (st.nib_idx)
            2'd0: begin
              st.word = {12'd0, nib};
              st.nib_idx = 2'd1;
            end
            2'd1: begin
              octet = {nib, st.word[3:0]};
              if (word_phase) begin
                st.word = {octet, 8'd0};
                st.nib_idx = 2'd2;
              end else begin
                st.word = {8'd0, octet};
                st.nib_idx = 2'd0;
                byte_done = 1'b1;
              end
            end
            2'd2: begin
              st.word = {st.word[15:8], 4'd0, nib};
              st.nib_idx = 2'd3;
            end
            default: begin
              octet = {nib, st.word[3:0]};
              st.word = {st.word[15:8], octet};
              st.nib_idx = 2'd0;
              word_done = 1'b1;
            end
          endcase
          // Frame sequencing.
          if (st.phase == PH_HUNT && byte_done) begin
            if (octet == cfg.open_byte) st.phase = PH_SIZE;
          end else if (st.phase == PH_SIZE && word_done) begin
            if (st.word == 16'd0) begin
              reply.ev = EV_END;
              st.phase = PH_HALT;
            end else begin
              st.block_size = st.word;
              st.phase = PH_CHECK;
            end
          end else if (st.phase == PH_CHECK && word_done) begin
            st.expected_sum = st.word;
            st.running_sum = 16'd0;
            st.bytes_done = 16'd0;
            st.phase = PH_DATA;
          end else if (st.phase == PH_DATA && byte_done) begin
            reply.byte_valid = 1'b1;
            reply.byte_value = octet;
            st.running_sum = st.running_sum + {8'd0, octet};
            st.bytes_done = st.bytes_done + 16'd1;
            if (st.bytes_done == st.block_size) begin
              reply.ev = (st.running_sum == st.expected_sum) ? EV_OK : EV_MISMATCH;
              reply.sum = st.running_sum;
              st.phase = PH_SIZE;
            end else begin
              reply.ev = EV_BYTE;
            end
          end
        end else begin
          // A sample without a nibble counts toward the timeout.
          st.wait_count = st.wait_count + 16'd1;
          if (st.wait_count >= cfg.timeout_limit) begin
            st.wait_count = 16'd0;
            st.nib_idx = 2'd0;
            st.prev_valid = 1'b0;
            if (st.phase == PH_HUNT) begin
              reply.ev = EV_RETRY;
            end else begin
              reply.ev = EV_TIMEOUT;
              st.phase = PH_HALT;
            end
          end
        end
      end
      reply.drive = st.drive;
    endfunction

    function void note_status(logic [4:0] status);
      rx_reply_t reply;
      receive_status(status, reply);
      due_replies.push_back(reply);
    endfunction

    function void report(string what);
      failures++;
      if (failures <= 10) $display("ERROR @%0t: %s", $realtime, what);
    endfunction

    function void check_reply(logic [4:0] drive, logic byte_valid, logic [7:0] byte_value,
                              logic [2:0] ev, logic [15:0] sum);
      rx_reply_t want;
      if (due_replies.size() == 0) begin
        report($sformatf("result transaction with none pending: drive %h ev %0d",
                         drive, ev));
      end else begin
        want = due_replies.pop_front();
        if (want.drive !== drive || want.byte_valid !== byte_valid ||
            want.byte_value !== byte_value || want.ev !== ev || want.sum !== sum)
          report($sformatf({"expected drive %h byte %b/%h ev %0d sum %h, ",
                            "got drive %h byte %b/%h ev %0d sum %h"},
                           want.drive, want.byte_valid, want.byte_value, want.ev,
                           want.sum, drive, byte_valid, byte_value, ev, sum));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_TIMEOUT;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  status_lines = 5'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  drive_value;
  logic        byte_valid;
  logic [7:0]  byte_value;
  logic [2:0]  event_res;
  logic [15:0] sum_value;

  nibble_rx_scoreboard sb;

  // Frame plans that steer the sample generator.
  logic [7:0]  hunt_byte = 8'd0;
  logic [15:0] size_plan = 16'd1;
  logic [15:0] check_plan = 16'd0;
  logic [7:0]  data_plan [512];
  bit          size_ready = 1'b0;
  bit          data_ready = 1'b0;
  bit          big_pending = 1'b0;
  bit          big_now = 1'b0;
  bit          closing = 1'b0;
  int          noise_left = 0;
  int          burst_left = 0;
  int          ready_run = 0;
  int          stall_run = 0;
  int          cycle_count = 0;

  parallel_nibble_frame_receiver_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .status_lines(status_lines),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive_value (drive_value),
    .byte_valid  (byte_valid),
    .byte_value  (byte_value),
    .event_res   (event_res),
    .sum_value   (sum_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver side: ready stretches broken by stalls of random length.
  always @(posedge clk) begin
    if (ready_run > 0) begin
      ready_run--;
      out_ready <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      out_ready <= 1'b0;
    end else begin
      ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
      stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      out_ready <= 1'b1;
    end
  end

  // Every result transaction is checked against the oldest pending reply.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_reply(drive_value, byte_valid, byte_value, event_res, sum_value);
  end

  // Watchdog.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Sends one sample; the sender idles between bursts of random length.
  task automatic send_status(input logic [4:0] status);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    status_lines <= status;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_status(status);
    burst_left--;
  endtask

  // Holds off until every pending reply has been checked.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.due_replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_one(input logic [1:0] idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  // Writes all four registers while the receiver is idle.
  task automatic set_regs(input logic [15:0] timeout_limit, input logic [7:0] magic,
                          input logic [3:0] hunt_ack, input logic [3:0] frame_ack);
    wait_idle();
    write_one(REG_TIMEOUT, timeout_limit);
    write_one(REG_MAGIC, {8'd0, magic});
    write_one(REG_HUNT_ACK, {12'd0, hunt_ack});
    write_one(REG_FRAME_ACK, {12'd0, frame_ack});
    cfg_wr_en <= 1'b0;
  endtask

  // The sample that moves the current frame forward by one nibble.
  function automatic logic [4:0] framed_status();
    logic [15:0] w;
    logic [7:0]  octet;
    logic [3:0]  nib;
    w = (sb.st.phase == PH_SIZE) ? size_plan : check_plan;
    octet = (sb.st.phase == PH_DATA) ? data_plan[sb.st.bytes_done[8:0]] : hunt_byte;
    if (sb.st.phase == PH_SIZE || sb.st.phase == PH_CHECK) begin
      case (sb.st.nib_idx)
        2'd0: nib = w[11:8];
        2'd1: nib = w[15:12];
        2'd2: nib = w[3:0];
        default: nib = w[7:4];
      endcase
    end else begin
      nib = sb.st.nib_idx[0] ? octet[7:4] : octet[3:0];
    end
    return {~sb.st.nib_idx[0], nib};
  endfunction

  // Picks the size word, payload and checksum as each frame begins.
  task automatic refresh_plans();
    logic [15:0] total;
    int          i;
    if (sb.st.phase != PH_SIZE) begin
      size_ready = 1'b0;
    end else if (!size_ready) begin
      size_ready = 1'b1;
      if (closing) begin
        size_plan = 16'd0;
      end else if (big_pending) begin
        // Long run of 0xff bytes so that the sum wraps past 16 bits.
        big_pending = 1'b0;
        big_now = 1'b1;
        size_plan = 16'd258;
      end else begin
        size_plan = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
      end
    end
    if (sb.st.phase != PH_CHECK && sb.st.phase != PH_DATA) begin
      data_ready = 1'b0;
    end else if (!data_ready) begin
      data_ready = 1'b1;
      total = 16'd0;
      for (i = 0; i < sb.st.block_size; i++) begin
        data_plan[i[8:0]] = big_now ? 8'hff : 8'($urandom_range(0, 255));
        total = total + {8'd0, data_plan[i[8:0]]};
      end
      check_plan = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : total;
      big_now = 1'b0;
    end
  endtask

  // Mostly well-formed frames; short noise bursts outside the size word.
  task automatic next_status(output logic [4:0] status);
    refresh_plans();
    if (!closing && sb.st.phase != PH_SIZE && noise_left == 0 &&
        $urandom_range(0, 15) == 0)
      noise_left = $urandom_range(1, 4);
    if (!closing && sb.st.phase != PH_SIZE && noise_left > 0) begin
      noise_left--;
      status = 5'($urandom_range(0, 31));
    end else begin
      status = framed_status();
    end
  endtask

  task automatic send_hunt_byte(input logic [7:0] value);
    hunt_byte = value;
    repeat (4) send_status(framed_status());
  endtask

  initial begin
    logic [4:0] status;
    int         n;
    bit         end_by_timeout;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Default registers: extreme samples, then a wrong start byte.
    send_status(5'h1f);
    send_status(5'h00);
    send_hunt_byte(8'h3c);

    // Short timeout while hunting: a wrong byte, then noise until a retry.
    set_regs(16'd2, 8'hff, 4'h0, FrameAckReset);
    send_hunt_byte(8'h00);
    send_status(5'h15);
    send_status(5'h0a);
    send_status(5'h1f);

    // Timeout limits of zero and one retry on every sample.
    set_regs(16'd0, 8'hff, 4'h0, FrameAckReset);
    send_status(5'h11);
    send_status(5'h11);
    set_regs(16'd1, 8'hff, 4'h0, FrameAckReset);
    send_status(5'h0e);
    send_status(5'h0e);

    // The start byte opens the transfer.
    set_regs(16'hffff, 8'h00, 4'hf, 4'hf);
    send_hunt_byte(8'h00);

    // Random frames under several register settings.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_regs(16'hffff, 8'hd7, 4'hb, 4'h0);
        1: set_regs(16'd16, 8'hff, 4'h0, 4'hf);
        2: begin
          set_regs(16'($urandom_range(16, 65535)), 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
          big_pending = 1'b1;
        end
        default: set_regs(16'($urandom_range(16, 2000)), 8'($urandom_range(0, 255)),
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      repeat (PhaseItems) begin
        next_status(status);
        send_status(status);
      end
    end

    // Terminal stop: either an end frame or a timeout after the start.
    end_by_timeout = 1'($urandom_range(0, 1));
    wait_idle();
    closing = 1'b1;
    if (end_by_timeout) begin
      set_regs(16'd5, 8'hd7, 4'hb, 4'h2);
      n = 0;
      while (sb.st.phase != PH_HALT && n < 100) begin
        send_status({sb.st.nib_idx[0], 4'($urandom_range(0, 15))});
        n++;
      end
    end else begin
      n = 0;
      while (sb.st.phase != PH_HALT && n < 4000) begin
        next_status(status);
        send_status(status);
        n++;
      end
    end

    // Halted: samples are still answered with the drive value held.
    repeat (6) send_status(5'($urandom_range(0, 31)));

    wait_idle();
    repeat (4) @(posedge clk);
    if (sb.failures == 0 && sb.due_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/pnfr_pkg.sv
rtl/parallel_nibble_frame_receiver_top.sv
dv/tb.sv
